// File: hdl/kmpc_pkg.sv
package kmpc_pkg;

  // Default geometry
  localparam int KMPC_ROWS       = 4;
  localparam int KMPC_COLS       = 4;
  localparam int KMPC_COUNT_BITS = 16;

  // Widest row index the geometry range allows (up to 16 rows)
  localparam int ROW_W_MAX = 4;

  // Configuration register map
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_PERIOD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_THRESHOLD  = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] SKIP_PERIOD_RST     = 16'd1;
  localparam logic [CFG_W-1:0] SHORT_THRESHOLD_RST = 16'd2;
  localparam logic [CFG_W-1:0] LONG_THRESHOLD_RST  = 16'd50;

  typedef struct packed {
    logic [CFG_W-1:0] skip_period;
    logic [CFG_W-1:0] short_threshold;
    logic [CFG_W-1:0] long_threshold;
  } cfg_t;

  // Scan decision for the item being processed
  typedef struct packed {
    logic                 scan;
    logic [ROW_W_MAX-1:0] row;
  } scan_t;

endpackage

// File: hdl/key_matrix_press_classifier.sv
// Key matrix press classifier.
// Slave stream s_*: one transfer per tick; s_tdata carries the column levels
// of the row driven for that tick (active low, one bit per column).
// Master stream m_*: exactly one result transfer per input transfer, in order,
// giving whether the tick scanned, the active row and the short/long release
// masks for that row.
// Configuration: cfg_we/cfg_index/cfg_data write skip_period (0),
// short_threshold (1) and long_threshold (2); other indexes are ignored.
// Flow: a tick accepted into the input register is processed by the prescaler
// and the hold counters of one row, and its result is loaded into the result
// register when that register is empty or being read. Throughput is one tick
// per cycle while m_tready is high, set by the single row of counters read per tick and written on scans.
// Reset clears the prescaler, the row counter and all hold counters, and
// loads the register defaults. When m_tready is low the result holds, one
// further tick waits in the input register, and s_tready then drops.
module key_matrix_press_classifier
  import kmpc_pkg::*;
#(
  parameter int ROWS       = KMPC_ROWS,
  parameter int COLS       = KMPC_COLS,
  parameter int COUNT_BITS = KMPC_COUNT_BITS,
  localparam int ROW_BITS  = (ROWS > 1) ? $clog2(ROWS) : 1,
  localparam int IN_W      = ((COLS + 7) / 8) * 8,
  localparam int OUT_BITS  = 1 + ROW_BITS + 2 * COLS,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_W-1:0]       s_tdata,   // col_levels
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_W-1:0]      m_tdata    // scanned, active_row, short_mask, long_mask
);

  cfg_t                cfg;
  scan_t               scan_info;
  logic                in_valid;
  logic [COLS-1:0]     in_levels;
  logic                advance;
  logic [COLS-1:0]     short_mask;
  logic [COLS-1:0]     long_mask;
  logic                out_scanned;
  logic [ROW_BITS-1:0] out_row;
  logic [COLS-1:0]     out_short;
  logic [COLS-1:0]     out_long;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.skip_period     <= SKIP_PERIOD_RST;
      cfg.short_threshold <= SHORT_THRESHOLD_RST;
      cfg.long_threshold  <= LONG_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SKIP_PERIOD:     cfg.skip_period     <= cfg_data;
        CFG_SHORT_THRESHOLD: cfg.short_threshold <= cfg_data;
        CFG_LONG_THRESHOLD:  cfg.long_threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Item moves from input register to result register
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_levels <= s_tdata[COLS-1:0];
    end
  end

  kmpc_scan_ctrl #(
    .ROWS (ROWS)
  ) u_scan_ctrl (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .cfg       (cfg),
    .scan_info (scan_info)
  );

  kmpc_key_store #(
    .ROWS       (ROWS),
    .COLS       (COLS),
    .COUNT_BITS (COUNT_BITS)
  ) u_key_store (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .cfg        (cfg),
    .scan_info  (scan_info),
    .col_levels (in_levels),
    .short_mask (short_mask),
    .long_mask  (long_mask)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_scanned <= scan_info.scan;
      out_row     <= scan_info.row[ROW_BITS-1:0];
      out_short   <= short_mask;
      out_long    <= long_mask;
    end
  end

  assign m_tdata = OUT_W'({out_long, out_short, out_row, out_scanned});

  // Checks
  a_masks_disjoint: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_short & out_long) == '0)
    else $error("short and long press on the same key");

  a_skip_no_events: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !out_scanned |-> out_short == '0 && out_long == '0)
    else $error("release reported on a skipped tick");

  a_row_in_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> {1'b0, out_row} <= (ROW_BITS + 1)'(ROWS - 1))
    else $error("active row out of range");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_valid && m_tvalid && !m_tready)
    else $error("input stalled without a pending result");

  a_result_follows_item: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("processed tick produced no result");

endmodule

// File: hdl/kmpc_scan_ctrl.sv
module kmpc_scan_ctrl
  import kmpc_pkg::*;
#(
  parameter int ROWS = KMPC_ROWS
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  cfg_t  cfg,
  output scan_t scan_info
);

  localparam int ROW_BITS = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [ROW_BITS-1:0] ROW_LAST = ROW_BITS'(ROWS - 1);

  logic [CFG_W-1:0]    tick_count;
  logic [ROW_BITS-1:0] current_row;
  logic [CFG_W:0]      tick_inc;
  logic [CFG_W-1:0]    period;
  logic                scan;
  logic [ROW_BITS-1:0] row_next;

  // Prescaler: a zero period behaves as one
  assign period   = (cfg.skip_period == '0) ? CFG_W'(1) : cfg.skip_period;
  assign tick_inc = {1'b0, tick_count} + (CFG_W + 1)'(1);
  assign scan     = tick_inc >= {1'b0, period};

  // Row advances on a scan, wrapping at the last row
  assign row_next = (current_row == ROW_LAST) ? '0 : current_row + ROW_BITS'(1);

  assign scan_info.scan = scan;
  assign scan_info.row  = scan ? ROW_W_MAX'(row_next) : ROW_W_MAX'(current_row);

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count  <= '0;
      current_row <= '0;
    end else if (advance) begin
      if (scan) begin
        tick_count  <= '0;
        current_row <= row_next;
      end else begin
        tick_count <= tick_inc[CFG_W-1:0];
      end
    end
  end

endmodule

// File: hdl/kmpc_key_store.sv
module kmpc_key_store
  import kmpc_pkg::*;
#(
  parameter int ROWS       = KMPC_ROWS,
  parameter int COLS       = KMPC_COLS,
  parameter int COUNT_BITS = KMPC_COUNT_BITS
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  cfg_t            cfg,
  input  scan_t           scan_info,
  input  logic [COLS-1:0] col_levels,
  output logic [COLS-1:0] short_mask,
  output logic [COLS-1:0] long_mask
);

  localparam int ROW_BITS = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CMP_W    = (COUNT_BITS > CFG_W) ? COUNT_BITS : CFG_W;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  logic [COUNT_BITS-1:0] hold_count [ROWS][COLS];
  logic [ROW_BITS-1:0]   row;
  logic [COUNT_BITS-1:0] cur   [COLS];
  logic [COUNT_BITS-1:0] upd   [COLS];
  logic [CMP_W-1:0]      short_thr;
  logic [CMP_W-1:0]      long_thr;

  assign row       = scan_info.row[ROW_BITS-1:0];
  assign short_thr = CMP_W'(cfg.short_threshold);
  assign long_thr  = CMP_W'(cfg.long_threshold);

  // Classify releases and form the new counts for the scanned row
  always_comb begin
    short_mask = '0;
    long_mask  = '0;
    for (int c = 0; c < COLS; c++) begin
      cur[c] = hold_count[row][c];
      if (col_levels[c]) begin
        if (CMP_W'(cur[c]) > long_thr) begin
          long_mask[c] = scan_info.scan;
        end else if (CMP_W'(cur[c]) > short_thr) begin
          short_mask[c] = scan_info.scan;
        end
        upd[c] = '0;
      end else if (cur[c] != COUNT_MAX) begin
        upd[c] = cur[c] + COUNT_BITS'(1);
      end else begin
        upd[c] = cur[c];
      end
    end
  end

  // Hold counters, one row written per scan
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int c = 0; c < COLS; c++) begin
          hold_count[r][c] <= '0;
        end
      end
    end else if (advance && scan_info.scan) begin
      for (int c = 0; c < COLS; c++) begin
        hold_count[row][c] <= upd[c];
      end
    end
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import kmpc_pkg::*;

  // Register index that the block has no register for
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // m_tdata layout, lowest bit first: scanned, active_row, short_mask, long_mask
  typedef struct packed {
    logic [4:0] pad;
    logic [3:0] long_mask;
    logic [3:0] short_mask;
    logic [1:0] active_row;
    logic       scanned;
  } scan_result_t;

  // Predicts one scan result per tick and checks results in order
  class press_scoreboard;
    logic [15:0]  period_reg;
    logic [15:0]  short_reg;
    logic [15:0]  long_reg;
    logic [15:0]  tick_cnt;
    logic [1:0]   row_q;
    logic [15:0]  key_hold [16];
    scan_result_t expected_q [$];
    int           errors;

    function new();
      period_reg = SKIP_PERIOD_RST;
      short_reg  = SHORT_THRESHOLD_RST;
      long_reg   = LONG_THRESHOLD_RST;
      tick_cnt   = '0;
      row_q      = '0;
      foreach (key_hold[k]) key_hold[k] = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_SKIP_PERIOD:     period_reg = val;
        CFG_SHORT_THRESHOLD: short_reg  = val;
        CFG_LONG_THRESHOLD:  long_reg   = val;
        default: ;
      endcase
    endfunction

    // Advance the prescaler, row and hold counters for one accepted tick
    function void note_tick(logic [3:0] levels);
      logic [16:0]  period;
      logic [16:0]  next_cnt;
      logic [3:0]   key;
      scan_result_t res;
      period   = (period_reg == '0) ? 17'd1 : {1'b0, period_reg};
      next_cnt = {1'b0, tick_cnt} + 17'd1;
      res      = '0;
      if (next_cnt < period) begin
        tick_cnt       = next_cnt[15:0];
        res.active_row = row_q;
      end else begin
        tick_cnt       = '0;
        row_q          = row_q + 2'd1;
        res.scanned    = 1'b1;
        res.active_row = row_q;
        for (int c = 0; c < 4; c++) begin
          key = {row_q, c[1:0]};
          if (levels[c]) begin
            // released: classify by how long it was held
            if (key_hold[key] > long_reg) res.long_mask[c] = 1'b1;
            else if (key_hold[key] > short_reg) res.short_mask[c] = 1'b1;
            key_hold[key] = '0;
          end else if (key_hold[key] != 16'hFFFF) begin
            key_hold[key] = key_hold[key] + 16'd1;
          end
        end
      end
      expected_q.push_back(res);
    endfunction

    function void report(string field, logic [15:0] exp_v, logic [15:0] got_v);
      errors++;
      $error("%s mismatch: expected %0h, got %0h", field, exp_v, got_v);
    endfunction

    function void check_result(logic [15:0] data);
      scan_result_t got;
      scan_result_t exp_r;
      got = data;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result transfer with nothing expected: %0h", data);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.scanned != exp_r.scanned)
        report("scanned", 16'(exp_r.scanned), 16'(got.scanned));
      if (got.active_row != exp_r.active_row)
        report("active_row", 16'(exp_r.active_row), 16'(got.active_row));
      if (got.short_mask != exp_r.short_mask)
        report("short_mask", 16'(exp_r.short_mask), 16'(got.short_mask));
      if (got.long_mask != exp_r.long_mask)
        report("long_mask", 16'(exp_r.long_mask), 16'(got.long_mask));
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;   // col_levels
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [15:0]          m_tdata;        // scanned, active_row, short_mask, long_mask

  press_scoreboard sb = new();
  bit              hold_off_req = 1'b0;
  logic [3:0]      levels_q = 4'hF;

  key_matrix_press_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("testbench: done, errors");
    $finish;
  end

  // Result side: check every transfer, stall on a changing duty pattern
  initial begin
    int stall_pct;
    int mode_left;
    int hold_left;
    stall_pct = 0;
    mode_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if (mode_left == 0) begin
        mode_left = $urandom_range(20, 120);
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
      end
      mode_left--;
      if (hold_off_req && hold_left == 0) begin
        hold_off_req = 1'b0;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // One tick transfer; returns at the edge where it was accepted
  task automatic send_tick(input logic [3:0] levels);
    s_tvalid <= 1'b1;
    s_tdata  <= {4'h0, levels};
    do @(posedge clk); while (!s_tready);
    sb.note_tick(levels);
  endtask

  task automatic stop_sending();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain all expected results, then let the pipeline settle
  task automatic wait_idle();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [15:0] period, input logic [15:0] short_t,
                            input logic [15:0] long_t);
    write_reg(CFG_SKIP_PERIOD, period);
    write_reg(CFG_SHORT_THRESHOLD, short_t);
    write_reg(CFG_LONG_THRESHOLD, long_t);
  endtask

  task automatic send_repeat(input logic [3:0] levels, input int n);
    for (int i = 0; i < n; i++) send_tick(levels);
  endtask

  // Key levels that mostly persist, so presses are held across scans
  function automatic logic [3:0] next_levels();
    logic [3:0] lv;
    lv = levels_q;
    if ($urandom_range(0, 99) < 12) begin
      lv = 4'($urandom_range(0, 15));
    end else begin
      for (int c = 0; c < 4; c++)
        if ($urandom_range(0, 5) == 0) lv[c] = ~lv[c];
    end
    levels_q = lv;
    return lv;
  endfunction

  // Random ticks in bursts with gaps between them
  task automatic run_random(input int n);
    int sent;
    int burst;
    int gap;
    sent = 0;
    while (sent < n) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < n; i++) begin
        send_tick(next_levels());
        sent++;
      end
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    stop_sending();
  endtask

  initial begin
    logic [15:0] random_cfg [5][3];
    random_cfg = '{'{16'd1, 16'd1, 16'd6}, '{16'd2, 16'd0, 16'd0},
                   '{16'd0, 16'd3, 16'hFFFF}, '{16'd3, 16'd2, 16'd8},
                   '{16'd1, 16'd0, 16'd4}};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Defaults: first scan is row 1; all keys held three scans -> short
    send_tick(4'hF);
    send_repeat(4'h0, 12);
    send_repeat(4'hF, 4);
    stop_sending();
    wait_idle();

    // Low thresholds: long and short releases in the same row
    set_config(16'd1, 16'd0, 16'd2);
    send_repeat(4'b0110, 12);
    send_repeat(4'b1001, 4);
    send_repeat(4'hF, 4);
    stop_sending();
    wait_idle();

    // Zero period scans every tick; a write to the unused index is ignored
    write_reg(CFG_SKIP_PERIOD, 16'd0);
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_repeat(4'b1010, 3);
    send_repeat(4'b0101, 3);
    stop_sending();
    wait_idle();

    // Longest period skips; lowering it below the count scans at once
    write_reg(CFG_SKIP_PERIOD, 16'hFFFF);
    send_repeat(4'h0, 6);
    stop_sending();
    wait_idle();
    write_reg(CFG_SKIP_PERIOD, 16'd3);
    send_repeat(4'hF, 6);
    stop_sending();
    wait_idle();

    // Random ticks under several settings; one long receiver hold-off
    for (int p = 0; p < 5; p++) begin
      set_config(random_cfg[p][0], random_cfg[p][1], random_cfg[p][2]);
      if (p == 1) hold_off_req = 1'b1;
      run_random(120);
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
